/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker module of the bin packer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define DFBP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion that is checked during reset as well.
`define DFBP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/dfbp_pkg.sv */
// Shared types and constants of the decreasing-fit bin packer.
package dfbp_pkg;

    localparam int DEFAULT_MAX_BINS = 8;

    localparam int UTIL_W    = 17;
    localparam int LOAD_W    = 17;
    localparam int SUM_W     = 18;
    localparam int BIN_IDX_W = 3;
    localparam int TDATA_W   = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 4;
    localparam int POLICY_W  = 2;
    localparam int COUNT_W   = 4;
    localparam int CMP_W     = 8;

    localparam logic [LOAD_W-1:0] FULL_LOAD = 17'd65536;

    localparam logic [POLICY_W-1:0] POL_BEST  = 2'd0;
    localparam logic [POLICY_W-1:0] POL_WORST = 2'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BINS_IN_USE = 2'd1;

    localparam logic [POLICY_W-1:0] RST_FIT_POLICY  = 2'd0;
    localparam logic [COUNT_W-1:0]  RST_BINS_IN_USE = 4'd8;

    typedef struct packed {
        logic              valid;
        logic              found;
        logic [LOAD_W-1:0] sum;
    } scan_t;

    typedef struct packed {
        logic              valid;
        logic [LOAD_W-1:0] sum;
    } commit_t;

endpackage

/* hw/rtl/dfbp_cell.sv */
// One bin of the packer: holds its load and updates the scan token passing through.
module dfbp_cell #(
    parameter int MAX_BINS = dfbp_pkg::DEFAULT_MAX_BINS,
    parameter int CELL_IDX = 0,
    parameter int IDX_W    = 3
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           clear,
    input  logic [dfbp_pkg::UTIL_W-1:0]    util,
    input  logic [dfbp_pkg::POLICY_W-1:0]  fit_policy,
    input  logic [dfbp_pkg::COUNT_W-1:0]   bins_in_use,
    input  dfbp_pkg::scan_t                scan_in,
    input  logic [IDX_W-1:0]               pick_in,
    output dfbp_pkg::scan_t                scan_out,
    output logic [IDX_W-1:0]               pick_out,
    input  dfbp_pkg::commit_t              commit,
    input  logic [IDX_W-1:0]               commit_pick
);
    import dfbp_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);
    localparam logic [CMP_W-1:0] MY_POS = CMP_W'(CELL_IDX);

    logic [LOAD_W-1:0] load_reg;
    logic              valid_reg;
    logic              found_reg;
    logic [LOAD_W-1:0] sum_reg;
    logic [IDX_W-1:0]  pick_reg;

    logic [SUM_W-1:0]  sum_full;
    logic              enabled;
    logic              fits;
    logic              take;

    assign enabled  = (MY_POS < CMP_W'(bins_in_use)) && (CELL_IDX < MAX_BINS);
    assign sum_full = {1'b0, load_reg} + {1'b0, util};
    assign fits     = enabled && (sum_full <= {1'b0, FULL_LOAD});

    always_comb begin
        take = 1'b0;
        if (fits) begin
            if (!scan_in.found) begin
                take = 1'b1;
            end else if (fit_policy == POL_BEST) begin
                take = sum_full > {1'b0, scan_in.sum};
            end else if (fit_policy == POL_WORST) begin
                take = sum_full < {1'b0, scan_in.sum};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_reg <= '0;
        end else if (clear) begin
            load_reg <= '0;
        end else if (commit.valid && (commit_pick == MY_IDX)) begin
            load_reg <= commit.sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= scan_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        found_reg <= scan_in.found || take;
        sum_reg   <= take ? sum_full[LOAD_W-1:0] : scan_in.sum;
        pick_reg  <= take ? MY_IDX : pick_in;
    end

    assign scan_out.valid = valid_reg;
    assign scan_out.found = found_reg;
    assign scan_out.sum   = sum_reg;
    assign pick_out       = pick_reg;

endmodule

/* hw/rtl/decreasing_fit_bin_packer.sv */
// Top level of the decreasing-fit bin packer: control, configuration and result registers.
//
// Each accepted task produces exactly one result. The bin loads live in a row of MAX_BINS
// cells, and a scan token walks that row one cell per clock; the result is registered from
// the output of the last cell. Once the failure flag is set, a task that does not start a
// new set skips the scan, and its result is registered from the skip flag instead. One task
// is in flight at a time. The next one is accepted as soon as the previous result sits in
// the output register; a result that has to wait in the hold register stalls the input
// until it moves on. Configuration writes are accepted in every cycle and should be issued
// only while idle.
module decreasing_fit_bin_packer #(
    parameter int MAX_BINS = dfbp_pkg::DEFAULT_MAX_BINS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [dfbp_pkg::TDATA_W-1:0]    s_tdata,   // task_util
    input  logic                            s_tuser,   // start_new
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dfbp_pkg::TDATA_W-1:0]    m_tdata,   // bin_index, new_load
    output logic                            m_tuser,   // failed
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dfbp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dfbp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dfbp_pkg::*;

    localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

    logic [POLICY_W-1:0]  fit_policy_reg;
    logic [COUNT_W-1:0]   bins_in_use_reg;
    logic [UTIL_W-1:0]    util_reg;
    logic                 busy_reg;
    logic                 launch_reg;
    logic                 skip_reg;
    logic                 sticky_reg;

    logic                 out_valid_reg;
    logic [BIN_IDX_W-1:0] out_bin_reg;
    logic                 out_failed_reg;
    logic [LOAD_W-1:0]    out_load_reg;
    logic                 hold_valid_reg;
    logic [BIN_IDX_W-1:0] hold_bin_reg;
    logic                 hold_failed_reg;
    logic [LOAD_W-1:0]    hold_load_reg;

    scan_t                scan  [MAX_BINS+1];
    logic [IDX_W-1:0]     picks [MAX_BINS+1];
    commit_t              commit;

    logic                 in_xfer;
    logic                 clear;
    logic                 sticky_eff;
    logic                 done;
    logic                 res_failed;
    logic [BIN_IDX_W-1:0] res_bin;
    logic [LOAD_W-1:0]    res_load;
    logic                 out_free;

    assign s_tready   = !busy_reg && !hold_valid_reg;
    assign in_xfer    = s_tvalid && s_tready;
    assign clear      = in_xfer && s_tuser;
    assign sticky_eff = s_tuser ? 1'b0 : sticky_reg;
    assign cfg_ready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fit_policy_reg  <= RST_FIT_POLICY;
            bins_in_use_reg <= RST_BINS_IN_USE;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_FIT_POLICY) begin
                fit_policy_reg <= cfg_data[POLICY_W-1:0];
            end else if (cfg_index == CFG_BINS_IN_USE) begin
                bins_in_use_reg <= cfg_data[COUNT_W-1:0];
            end
        end
    end

    assign scan[0].valid = launch_reg;
    assign scan[0].found = 1'b0;
    assign scan[0].sum   = '0;
    assign picks[0]      = '0;

    for (genvar g = 0; g < MAX_BINS; g++) begin : g_cell
        dfbp_cell #(
            .MAX_BINS (MAX_BINS),
            .CELL_IDX (g),
            .IDX_W    (IDX_W)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .clear       (clear),
            .util        (util_reg),
            .fit_policy  (fit_policy_reg),
            .bins_in_use (bins_in_use_reg),
            .scan_in     (scan[g]),
            .pick_in     (picks[g]),
            .scan_out    (scan[g+1]),
            .pick_out    (picks[g+1]),
            .commit      (commit),
            .commit_pick (picks[MAX_BINS])
        );
    end

    assign commit.valid = scan[MAX_BINS].valid && scan[MAX_BINS].found;
    assign commit.sum   = scan[MAX_BINS].sum;

    assign done       = skip_reg || scan[MAX_BINS].valid;
    assign res_failed = skip_reg || !scan[MAX_BINS].found;
    assign res_bin    = res_failed ? '0 : BIN_IDX_W'(picks[MAX_BINS]);
    assign res_load   = res_failed ? '0 : scan[MAX_BINS].sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            launch_reg <= 1'b0;
            skip_reg   <= 1'b0;
            sticky_reg <= 1'b0;
        end else begin
            launch_reg <= in_xfer && !sticky_eff;
            skip_reg   <= in_xfer && sticky_eff;
            if (in_xfer) begin
                busy_reg   <= 1'b1;
                sticky_reg <= sticky_eff;
            end else if (done) begin
                busy_reg <= 1'b0;
                if (res_failed) begin
                    sticky_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            util_reg <= s_tdata[UTIL_W-1:0];
        end
    end

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else begin
            if (done) begin
                if (out_free) begin
                    out_valid_reg <= 1'b1;
                end else begin
                    hold_valid_reg <= 1'b1;
                end
            end else if (m_tready) begin
                out_valid_reg  <= hold_valid_reg;
                hold_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            if (out_free) begin
                out_bin_reg    <= res_bin;
                out_failed_reg <= res_failed;
                out_load_reg   <= res_load;
            end else begin
                hold_bin_reg    <= res_bin;
                hold_failed_reg <= res_failed;
                hold_load_reg   <= res_load;
            end
        end else if (m_tready && hold_valid_reg) begin
            out_bin_reg    <= hold_bin_reg;
            out_failed_reg <= hold_failed_reg;
            out_load_reg   <= hold_load_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_failed_reg;
    assign m_tdata  = {{(TDATA_W - LOAD_W - BIN_IDX_W){1'b0}}, out_load_reg, out_bin_reg};

endmodule

/* hw/rtl/dfbp_checker.sv */
// Port-level checker of the decreasing-fit bin packer and its bind statement.
`include "assert_macros.svh"

module dfbp_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [dfbp_pkg::TDATA_W-1:0]    m_tdata,
    input logic                            m_tuser
);
    import dfbp_pkg::*;

    `DFBP_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
    `DFBP_ASSERT(a_fail_zero, aclk, aresetn, m_tvalid && m_tuser |-> m_tdata == '0, "failed result carries data")
    `DFBP_ASSERT(a_load_max, aclk, aresetn, m_tvalid && !m_tuser |-> m_tdata[LOAD_W+BIN_IDX_W-1:BIN_IDX_W] <= FULL_LOAD, "load above one")
    `DFBP_ASSERT(a_one_task, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "second task accepted while busy")
    `DFBP_ASSERT_ALWAYS(a_rst_idle, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind decreasing_fit_bin_packer dfbp_checker u_dfbp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* sim/decreasing_fit_bin_packer_tb.sv */
// Self-checking testbench for the decreasing-fit bin packer: task stream, policy and bin checks.
module decreasing_fit_bin_packer_tb;
    import dfbp_pkg::*;

    localparam int NUM_BINS = DEFAULT_MAX_BINS;
    localparam int SETTLE_CYCLES = NUM_BINS + 4;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int PHASE_TASKS = 110;
    localparam logic [POLICY_W-1:0] POL_FIRST = 2'd2;
    localparam logic [POLICY_W-1:0] POL_SPARE = 2'd3;

    typedef struct {
        logic [BIN_IDX_W-1:0] bin_index;
        logic                 failed;
        logic [LOAD_W-1:0]    new_load;
    } placement_t;

    class placement_scoreboard;
        logic [POLICY_W-1:0] fit_policy;
        logic [COUNT_W-1:0]  bins_in_use;
        logic [LOAD_W-1:0]   bin_load [NUM_BINS];
        bit                  sticky_fail;
        placement_t          expected_q [$];
        int unsigned         mismatches;

        function new();
            fit_policy  = RST_FIT_POLICY;
            bins_in_use = RST_BINS_IN_USE;
            foreach (bin_load[j]) bin_load[j] = '0;
            sticky_fail = 1'b0;
            mismatches  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_FIT_POLICY) begin
                fit_policy = val[POLICY_W-1:0];
            end else if (idx == CFG_BINS_IN_USE) begin
                bins_in_use = val;
            end
        endfunction

        function void note_task(logic [UTIL_W-1:0] util, bit start_new);
            int unsigned      count;
            int unsigned      pick;
            logic [SUM_W-1:0] sum;
            logic [SUM_W-1:0] pick_sum;
            bit               found;
            bit               take;
            placement_t       res;
            pick = 0;
            pick_sum = '0;
            found = 1'b0;
            if (start_new) begin
                foreach (bin_load[j]) bin_load[j] = '0;
                sticky_fail = 1'b0;
            end
            count = (bins_in_use > NUM_BINS) ? NUM_BINS : bins_in_use;
            if (!sticky_fail) begin
                for (int unsigned j = 0; j < count; j++) begin
                    sum = bin_load[j] + util;
                    if (sum <= FULL_LOAD) begin
                        if (!found) begin
                            take = 1'b1;
                        end else if (fit_policy == POL_BEST) begin
                            take = sum > pick_sum;
                        end else if (fit_policy == POL_WORST) begin
                            take = sum < pick_sum;
                        end else begin
                            take = 1'b0;
                        end
                        if (take) begin
                            found = 1'b1;
                            pick = j;
                            pick_sum = sum;
                        end
                    end
                end
                if (found) begin
                    bin_load[pick] = pick_sum[LOAD_W-1:0];
                end else begin
                    sticky_fail = 1'b1;
                end
            end
            if (sticky_fail) begin
                res.bin_index = '0;
                res.failed = 1'b1;
                res.new_load = '0;
            end else begin
                res.bin_index = pick[BIN_IDX_W-1:0];
                res.failed = 1'b0;
                res.new_load = pick_sum[LOAD_W-1:0];
            end
            expected_q.push_back(res);
        endfunction

        function void check_result(placement_t got);
            placement_t want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected result transfer: bin %0d failed %0d load %0d",
                             got.bin_index, got.failed, got.new_load);
                end
                return;
            end
            want = expected_q.pop_front();
            if (got.bin_index !== want.bin_index || got.failed !== want.failed ||
                got.new_load !== want.new_load) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display({"Mismatch: expected bin %0d failed %0d load %0d, ",
                              "got bin %0d failed %0d load %0d"},
                             want.bin_index, want.failed, want.new_load,
                             got.bin_index, got.failed, got.new_load);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [TDATA_W-1:0]    s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    bit calm = 1'b0;
    bit hold_request = 1'b0;
    placement_scoreboard placements = new();

    decreasing_fit_bin_packer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Sample every result transfer at the rising edge.
    always @(posedge aclk) begin
        placement_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.bin_index = m_tdata[BIN_IDX_W-1:0];
            got.new_load  = m_tdata[BIN_IDX_W +: LOAD_W];
            got.failed    = m_tuser;
            placements.check_result(got);
        end
    end

    // Result side back-pressure, including one long hold-off on request.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge aclk);
                hold_request = 1'b0;
                m_tready <= 1'b1;
            end else if (aresetn && !calm && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Called at a falling edge; lowers tvalid there and idles for the given cycles.
    task automatic idle_sender(input int unsigned cycles);
        s_tvalid <= 1'b0;
        s_tdata  <= TDATA_W'($urandom);
        s_tuser  <= 1'($urandom_range(0, 1));
        repeat (cycles) @(negedge aclk);
    endtask

    task automatic send_task(input logic [UTIL_W-1:0] util, input bit start_new);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(TDATA_W-UTIL_W){1'b0}}, util};
        s_tuser  <= start_new;
        do @(posedge aclk); while (!s_tready);
        placements.note_task(util, start_new);
        @(negedge aclk);
        if (!calm && $urandom_range(0, 3) == 0) begin
            idle_sender($urandom_range(1, 10));
        end
    endtask

    task automatic drain_results();
        idle_sender(0);
        while (placements.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        placements.write_reg(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_policy(input logic [POLICY_W-1:0] pol);
        logic [1:0] upper;
        upper = 2'($urandom_range(0, 3));
        write_reg(CFG_FIT_POLICY, {upper, pol});
    endtask

    // One task set: a fresh start followed by utilizations largest first,
    // occasionally left unsorted or mixed with oversized noise.
    task automatic send_task_set(inout int unsigned sent);
        int unsigned      set_len;
        int unsigned      shift;
        int unsigned      sizes [$];
        logic [UTIL_W-1:0] util;
        set_len = $urandom_range(1, 20);
        for (int k = 0; k < set_len; k++) begin
            shift = $urandom_range(0, 4);
            sizes.push_back($urandom_range(0, FULL_LOAD >> shift));
        end
        if ($urandom_range(0, 7) != 0) sizes.rsort();
        foreach (sizes[k]) begin
            util = UTIL_W'(sizes[k]);
            if ($urandom_range(0, 19) == 0) util = UTIL_W'($urandom);
            send_task(util, k == 0 || $urandom_range(0, 49) == 0);
            sent++;
        end
    endtask

    initial begin
        logic [POLICY_W-1:0] phase_policy [10];
        logic [COUNT_W-1:0]  phase_bins [10];
        int unsigned sent;
        bit          long_hold_done;

        phase_policy = '{POL_BEST, POL_WORST, POL_FIRST, POL_SPARE,
                         POL_BEST, POL_WORST, POL_FIRST, POL_BEST,
                         POL_WORST, POL_FIRST};
        phase_bins = '{4'd8, 4'd1, 4'd3, 4'd15, 4'd0,
                       4'd5, 4'd8, 4'd2, 4'd9, 4'd8};
        long_hold_done = 1'b0;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings: best fit over all bins.
        send_task(17'd0, 1'b1);
        send_task(17'd65536, 1'b0);
        send_task(17'd65537, 1'b0);
        send_task(17'd1, 1'b0);
        send_task(17'd131071, 1'b1);
        send_task(17'd40000, 1'b1);
        send_task(17'd30000, 1'b0);
        send_task(17'd20000, 1'b0);

        set_policy(POL_WORST);
        send_task(17'd40000, 1'b1);
        send_task(17'd30000, 1'b0);
        send_task(17'd20000, 1'b0);

        set_policy(POL_FIRST);
        send_task(17'd40000, 1'b1);
        send_task(17'd30000, 1'b0);
        send_task(17'd20000, 1'b0);

        set_policy(POL_SPARE);
        send_task(17'd40000, 1'b1);
        send_task(17'd30000, 1'b0);

        write_reg(CFG_BINS_IN_USE, 4'd0);
        send_task(17'd0, 1'b1);

        write_reg(CFG_BINS_IN_USE, 4'd1);
        set_policy(POL_BEST);
        send_task(17'd65536, 1'b1);
        send_task(17'd0, 1'b0);
        send_task(17'd1, 1'b0);

        write_reg(CFG_BINS_IN_USE, 4'd15);
        send_task(17'd65536, 1'b1);
        send_task(17'd65535, 1'b0);
        send_task(17'd65536, 1'b0);

        for (int p = 0; p < 10; p++) begin
            if (p == 9) calm = 1'b1;
            set_policy(phase_policy[p]);
            write_reg(CFG_BINS_IN_USE, phase_bins[p]);
            sent = 0;
            while (sent < PHASE_TASKS) begin
                if (p == 2 && sent >= 40 && !long_hold_done) begin
                    hold_request = 1'b1;
                    long_hold_done = 1'b1;
                end
                if (p == 5 && sent >= 50 && sent < 70) begin
                    idle_sender(0);
                    while (placements.pending() != 0) @(posedge aclk);
                    @(negedge aclk);
                end
                send_task_set(sent);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (placements.mismatches == 0 && placements.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/dfbp_pkg.sv
hw/rtl/dfbp_cell.sv
hw/rtl/decreasing_fit_bin_packer.sv
hw/rtl/dfbp_checker.sv
sim/decreasing_fit_bin_packer_tb.sv
